// ===== rtl/core/qske_pkg.sv =====
// ----------------------------------------------------------------------------
// qske_pkg
// Shared types, constants and coefficient table for the quadratic kernel.
// ----------------------------------------------------------------------------
package qske_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam logic [1:0] REG_KSEL = 2'd0;
	localparam logic [1:0] REG_DIM  = 2'd1;
	localparam logic [1:0] REG_RAD  = 2'd2;

	typedef struct packed {
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] disp_z;
	} qske_in_t;

	typedef struct packed {
		logic signed [WORD_BITS_DEF-1:0] weight_value;
		logic signed [WORD_BITS_DEF-1:0] grad_x;
		logic signed [WORD_BITS_DEF-1:0] grad_y;
		logic signed [WORD_BITS_DEF-1:0] grad_z;
		logic signed [WORD_BITS_DEF-1:0] laplacian_value;
		logic                            inside_support;
		logic                            saturated;
	} qske_out_t;

	// Q32.32 magnitude with overflow flag
	typedef struct packed {
		logic        big;
		logic [63:0] m;
	} wide_t;

	// coefficient: kernel, dimension (1..3), slot (0 weight, 1 grad, 2 lap)
	function automatic logic [63:0] coef(input logic ks, input logic [1:0] d,
		input logic [1:0] slot);
		logic [63:0] c;
		c = 64'd0;
		case ({ks, d, slot})
			5'b0_01_00: c = 64'd6442450944;
			5'b0_01_01: c = 64'd12884901888;
			5'b0_01_10: c = 64'd12884901888;
			5'b0_10_00: c = 64'd8202783307;
			5'b0_10_01: c = 64'd16405566614;
			5'b0_10_10: c = 64'd16405566614;
			5'b0_11_00: c = 64'd10253479134;
			5'b0_11_01: c = 64'd20506958267;
			5'b0_11_10: c = 64'd20506958267;
			5'b1_01_00: c = 64'd3221225472;
			5'b1_01_01: c = 64'd6442450944;
			5'b1_01_10: c = 64'd6442450944;
			5'b1_10_00: c = 64'd2734261102;
			5'b1_10_01: c = 64'd5468522205;
			5'b1_10_10: c = 64'd10937044409;
			5'b1_11_00: c = 64'd2563369783;
			5'b1_11_01: c = 64'd5126739567;
			5'b1_11_10: c = 64'd15380218700;
			default:    c = 64'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/qske_mul.sv =====
// ----------------------------------------------------------------------------
// qske_mul
// Pipelined Q32.32 multiply with overflow tracking: four 32x32 partial
// products in one stage, summed in the next.
// ----------------------------------------------------------------------------
module qske_mul (
	input  logic               clk,
	input  logic               en,
	input  qske_pkg::wide_t    a,
	input  qske_pkg::wide_t    b,
	output qske_pkg::wide_t    p
);
	import qske_pkg::*;

	logic [63:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic        zero_s1, big_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= 64'(a.m[31:0]) * 64'(b.m[31:0]);
			p1_s1   <= 64'(a.m[31:0]) * 64'(b.m[63:32]);
			p2_s1   <= 64'(a.m[63:32]) * 64'(b.m[31:0]);
			p3_s1   <= 64'(a.m[63:32]) * 64'(b.m[63:32]);
			zero_s1 <= (!a.big && a.m == 64'd0) || (!b.big && b.m == 64'd0);
			big_s1  <= a.big || b.big;
		end
	end

	logic [127:0] sum;
	assign sum = {64'd0, p0_s1} + {32'd0, p1_s1, 32'd0} + {32'd0, p2_s1, 32'd0}
		+ {p3_s1, 64'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s1) begin
				p <= '{big: 1'b0, m: 64'd0};
			end else if (big_s1 || sum[127:96] != 32'd0) begin
				p <= '{big: 1'b1, m: 64'd0};
			end else begin
				p <= '{big: 1'b0, m: sum[95:32]};
			end
		end
	end

endmodule

// ===== rtl/core/quadratic_sph_kernel_eval.sv =====
// ----------------------------------------------------------------------------
// quadratic_sph_kernel_eval
// Quadratic SPH smoothing kernel: weight, gradient and Laplacian.
// ----------------------------------------------------------------------------
// One displacement word enters per clock and one result word leaves per
// clock; the whole pipeline holds only while a result word waits with
// out_ready low. Each displacement word passes through the chain of stages:
// magnitudes, squares and sum, a 32-step pipelined square root (one result
// bit per stage), 64-step pipelined restoring dividers for r/R, 1/R and the
// direction cosines (one quotient bit per stage), one setup stage, a second
// 64-step divider for the Johnson Laplacian quotient, eight rounds of
// Q32.32 multipliers that apply the coefficient, the powers of 1/R and the
// direction, and the output register. Configuration words may be written
// only while the pipeline is empty. Outside the support every field is zero;
// at the center the gradient points along -x, and the Johnson Laplacian in
// two or three dimensions clamps to the maximum and raises saturated.
// ----------------------------------------------------------------------------
module quadratic_sph_kernel_eval #(
	parameter int FRAC_BITS = qske_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qske_pkg::qske_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qske_pkg::qske_out_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [30:0]         cfg_data
);
	import qske_pkg::*;

	localparam int WORD_BITS = WORD_BITS_DEF;

	// Stage budget of each section.
	localparam int SQ_ST  = 32;  // square root bits
	localparam int DV_ST  = 64;  // quotient bits
	localparam int NR     = 8;   // multiplier rounds
	localparam int NS     = 2 + SQ_ST + DV_ST + 1 + DV_ST + 2 * NR;

	// ---------------------------------------------------------------- config
	logic        ksel_q;
	logic [1:0]  dim_q;
	logic [30:0] rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksel_q <= 1'b0;
			dim_q  <= 2'd3;
			rad_q  <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KSEL: ksel_q <= cfg_data[0];
				REG_DIM:  dim_q  <= cfg_data[1:0];
				REG_RAD:  rad_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	logic [1:0]  dim;
	logic [63:0] rad;
	assign dim = (dim_q == 2'd0) ? 2'd1 : dim_q;
	assign rad = (rad_q == 31'd0) ? 64'd1 : 64'(rad_q);

	// Whole pipeline advances together; output stage is a register.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// --------------------------------------------------------- generic stage
	// Valid bits and common per-item side data travel in shift lines.
	logic [NS-1:0] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	// ------------------------------------------------------ s1: magnitudes
	logic [31:0] mag_s1 [3];
	logic [2:0]  neg_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				logic [31:0] v;
				v = (j == 0) ? in_data.disp_x : (j == 1) ? in_data.disp_y
					: in_data.disp_z;
				if (2'(j) < dim) begin
					neg_s1[j] <= v[31];
					mag_s1[j] <= v[31] ? 32'(~v + 32'd1) : v;
				end else begin
					neg_s1[j] <= 1'b0;
					mag_s1[j] <= 32'd0;
				end
			end
		end
	end
	// magnitude of -2^31 is 2^31, which still fits in 32 bits
	// (~v+1 = 0x80000000).

	// ------------------------------------------------------ s2: sum squares
	logic [65:0] sum_s2;
	logic [31:0] mag_s2 [3];
	logic [2:0]  neg_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= 66'(64'(mag_s1[0]) * 64'(mag_s1[0]))
				+ 66'(64'(mag_s1[1]) * 64'(mag_s1[1]))
				+ 66'(64'(mag_s1[2]) * 64'(mag_s1[2]));
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	logic inside_s2;
	assign inside_s2 = sum_s2 <= 66'(rad * rad);

	// ---------------------------------------------------- square root line
	// Digit-by-digit recurrence on a 64-bit radicand, one bit a stage.
	// The sum can reach 3*2^62 < 2^64, so 64 bits hold it.
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] rt;
		logic [2:0]  neg;
		logic [95:0] mag;
		logic        ins;
	} sq_t;
	sq_t sq_s [SQ_ST+1];
	always_comb begin
		sq_s[0].rem = sum_s2[63:0];
		sq_s[0].rt  = 64'd0;
		sq_s[0].neg = neg_s2;
		sq_s[0].mag = {mag_s2[0], mag_s2[1], mag_s2[2]};
		sq_s[0].ins = inside_s2;
	end
	for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
		localparam int SH = 62 - 2 * k;
		always_ff @(posedge clk) begin
			if (adv) begin
				logic [63:0] bt, trial;
				bt    = 64'd1 << SH;
				trial = sq_s[k].rt + bt;
				if (sq_s[k].rem >= trial) begin
					sq_s[k+1].rem <= sq_s[k].rem - trial;
					sq_s[k+1].rt  <= (sq_s[k].rt >> 1) + bt;
				end else begin
					sq_s[k+1].rem <= sq_s[k].rem;
					sq_s[k+1].rt  <= sq_s[k].rt >> 1;
				end
				sq_s[k+1].neg <= sq_s[k].neg;
				sq_s[k+1].mag <= sq_s[k].mag;
				sq_s[k+1].ins <= sq_s[k].ins;
			end
		end
	end
	logic [63:0] r_w;
	assign r_w = sq_s[SQ_ST].rt;

	// --------------------------------------------------- divider line one
	// Five parallel quotients, shared stage shape: r/R, 1/R (Q FRAC), and
	// |d_j|/r for the three components.
	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] lo;
		logic [63:0] q;
		logic [63:0] d;
		logic        big;
	} dv_t;

	function automatic dv_t dv_init(input logic [63:0] n, input logic [63:0] d);
		dv_t o;
		o.rem = 64'(n >> 32);
		o.lo  = n << 32;
		o.q   = 64'd0;
		o.d   = d;
		o.big = (d == 64'd0) || (64'(n >> 32) >= d);
		return o;
	endfunction

	function automatic dv_t dv_step(input dv_t x);
		dv_t o;
		logic        c;
		logic [63:0] rm;
		c  = x.rem[63];
		rm = {x.rem[62:0], x.lo[63]};
		o  = x;
		o.lo = {x.lo[62:0], 1'b0};
		if (c || rm >= x.d) begin
			o.rem = rm - x.d;
			o.q   = {x.q[62:0], 1'b1};
		end else begin
			o.rem = rm;
			o.q   = {x.q[62:0], 1'b0};
		end
		return o;
	endfunction

	typedef struct packed {
		logic [63:0] r;
		logic [2:0]  neg;
		logic        ins;
	} side_t;

	dv_t   da_s [5][DV_ST+1];
	side_t sa_s [DV_ST+1];
	always_comb begin
		da_s[0][0] = dv_init(r_w, rad);
		da_s[1][0] = dv_init(64'd1 << FRAC_BITS, rad);
		da_s[2][0] = dv_init(64'(sq_s[SQ_ST].mag[95:64]), r_w);
		da_s[3][0] = dv_init(64'(sq_s[SQ_ST].mag[63:32]), r_w);
		da_s[4][0] = dv_init(64'(sq_s[SQ_ST].mag[31:0]), r_w);
		sa_s[0]    = '{r: r_w, neg: sq_s[SQ_ST].neg, ins: sq_s[SQ_ST].ins};
	end
	for (genvar k = 0; k < DV_ST; k++) begin : g_div_a
		for (genvar u = 0; u < 5; u++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) begin
					da_s[u][k+1] <= dv_step(da_s[u][k]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sa_s[k+1] <= sa_s[k];
			end
		end
	end

	// ------------------------------------------- stage B: polynomial setup
	// ratio, 1/R, cosines and Johnson Laplacian numerator.
	logic [63:0] ratio_w;
	wide_t       inv_w;
	logic        center_w;
	assign center_w = sa_s[DV_ST].r == 64'd0;
	assign ratio_w  = center_w ? 64'd0 : da_s[0][DV_ST].q;
	assign inv_w    = '{big: da_s[1][DV_ST].big, m: da_s[1][DV_ST].q};

	typedef struct packed {
		logic [63:0] ratio;
		wide_t       inv;
		wide_t [2:0] cosv;
		logic        center;
		logic [2:0]  neg;
		logic        ins;
		logic [63:0] lnum;
		logic        lneg;
	} b_t;
	b_t b_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic [65:0] t, off;
			t   = 66'(dim) * 66'(ratio_w);
			off = 66'(dim - 2'd1) << 32;
			b_s1.ratio  <= ratio_w;
			b_s1.inv    <= inv_w;
			for (int u = 0; u < 3; u++)
				b_s1.cosv[u] <= '{big: da_s[u+2][DV_ST].big, m: da_s[u+2][DV_ST].q};
			b_s1.center <= center_w;
			b_s1.neg    <= sa_s[DV_ST].neg;
			b_s1.ins    <= sa_s[DV_ST].ins;
			b_s1.lneg   <= t < off;
			b_s1.lnum   <= (t >= off) ? 64'(t - off) : 64'(off - t);
		end
	end

	// -------------------------------------- divider line two: Laplacian q
	// lnum stays below 2^34 inside the support, so the single-bit-wide top
	// quotient check is handled by the same init.
	dv_t   db_s [DV_ST+1];
	b_t    sb_s [DV_ST+1];
	always_comb begin
		db_s[0] = dv_init(b_s1.lnum, b_s1.ratio);
		sb_s[0] = b_s1;
	end
	for (genvar k = 0; k < DV_ST; k++) begin : g_div_b
		always_ff @(posedge clk) begin
			if (adv) begin
				db_s[k+1] <= dv_step(db_s[k]);
				sb_s[k+1] <= sb_s[k];
			end
		end
	end

	// --------------------------------------- multiplier chain (eight rounds)
	// Round 0: poly setup products (v*v or ratio^2). Round 1: coefficient.
	// Rounds 2..: times 1/R while the power count lasts, then direction.
	b_t    bb;
	wide_t qlap;
	assign bb   = sb_s[DV_ST];
	assign qlap = '{big: db_s[DV_ST].big, m: db_s[DV_ST].q};

	typedef struct packed {
		wide_t       w;
		wide_t       g;
		wide_t       l;
		wide_t [2:0] gd;
		logic [63:0] ratio;
		logic [2:0]  neg;
		logic        center;
		logic        ins;
		logic        lneg;
		wide_t       inv;
		wide_t [2:0] cosv;
	} m_t;

	m_t mc [NR+1];
	// Each round drives six multipliers; unneeded ones see 1.0.
	localparam logic [63:0] ONE = 64'd1 << 32;

	always_comb begin
		mc[0].w      = '{big: 1'b0, m: ONE - bb.ratio};
		mc[0].g      = '{big: 1'b0, m: ksel_q ? bb.ratio : ONE - bb.ratio};
		mc[0].l      = (ksel_q || dim == 2'd1) ? '{big: 1'b0, m: ONE} : qlap;
		mc[0].gd     = '0;
		mc[0].ratio  = bb.ratio;
		mc[0].neg    = bb.neg;
		mc[0].center = bb.center;
		mc[0].ins    = bb.ins;
		mc[0].lneg   = ksel_q ? 1'b1 : (dim == 2'd1 ? 1'b0 : bb.lneg);
		mc[0].inv    = bb.inv;
		mc[0].cosv   = bb.cosv;
	end

	for (genvar k = 0; k < NR; k++) begin : g_round
		wide_t aw, bw, ag, bg, al, bl;
		wide_t [2:0] ad, bd;
		wide_t pw, pg, pl;
		wide_t [2:0] pd;
		m_t    dl1, dl2;
		// Johnson: k0 v*v, dome: k0 ratio*ratio then 1 - x
		always_comb begin
			aw = mc[k].w; bw = '{big: 1'b0, m: ONE};
			ag = mc[k].g; bg = '{big: 1'b0, m: ONE};
			al = mc[k].l; bl = '{big: 1'b0, m: ONE};
			ad = mc[k].gd; bd = '{default: '{big: 1'b0, m: ONE}};
			if (k == 0) begin
				aw = ksel_q ? '{big: 1'b0, m: mc[k].ratio} : mc[k].w;
				bw = ksel_q ? '{big: 1'b0, m: mc[k].ratio} : mc[k].w;
			end else if (k == 1) begin
				bw = '{big: 1'b0, m: coef(ksel_q, dim, 2'd0)};
				bg = '{big: 1'b0, m: coef(ksel_q, dim, 2'd1)};
				bl = '{big: 1'b0, m: coef(ksel_q, dim, 2'd2)};
			end else begin
				if (k - 2 < int'(dim))      bw = mc[k].inv;
				if (k - 2 < int'(dim) + 1)  bg = mc[k].inv;
				if (k - 2 < (ksel_q ? int'(dim) + 2 : (dim == 2'd1 ? 3
					: int'(dim) + 2)))      bl = mc[k].inv;
				if (k == NR - 1) begin
					for (int u = 0; u < 3; u++) begin
						ad[u] = mc[k].g;
						bd[u] = mc[k].cosv[u];
					end
				end
			end
		end
		qske_mul u_mw (.clk, .en(adv), .a(aw), .b(bw), .p(pw));
		qske_mul u_mg (.clk, .en(adv), .a(ag), .b(bg), .p(pg));
		qske_mul u_ml (.clk, .en(adv), .a(al), .b(bl), .p(pl));
		for (genvar u = 0; u < 3; u++) begin : g_dir
			qske_mul u_md (.clk, .en(adv), .a(ad[u]), .b(bd[u]), .p(pd[u]));
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dl1 <= mc[k];
				dl2 <= dl1;
			end
		end
		always_comb begin
			mc[k+1]    = dl2;
			mc[k+1].w  = (k == 0 && ksel_q) ? '{big: 1'b0, m: ONE - pw.m} : pw;
			mc[k+1].g  = pg;
			mc[k+1].l  = pl;
			mc[k+1].gd = pd;
		end
	end
	// Dim at most 3: weight needs 3, gradient 4, Laplacian 5 inverse
	// rounds; rounds 2..6 give five, round 7 adds the direction.

	// ------------------------------------------------------- output stage
	localparam logic [63:0] LIMP = (64'd1 << (WORD_BITS - 1)) - 64'd1;
	localparam logic [63:0] LIMN = 64'd1 << (WORD_BITS - 1);

	function automatic logic [WORD_BITS:0] to_out(input wide_t t, input logic neg);
		logic [63:0] lim, mg, r;
		logic        f;
		lim = neg ? LIMN : LIMP;
		f   = 1'b0;
		mg  = t.m >> (32 - FRAC_BITS);
		if (t.big || mg > lim) begin
			mg = lim;
			f  = 1'b1;
		end
		r = neg ? 64'(64'd0 - mg) : mg;
		return {f, r[WORD_BITS-1:0]};
	endfunction

	m_t fin;
	assign fin = mc[NR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			logic [WORD_BITS:0] ow, ox, oy, oz, ol;
			logic               s;
			ow = to_out(fin.w, 1'b0);
			if (fin.center) begin
				ox = to_out(fin.g, 1'b1);
				oy = '0;
				oz = '0;
			end else begin
				ox = to_out(fin.gd[0], !fin.neg[0]);
				oy = (dim >= 2'd2) ? to_out(fin.gd[1], !fin.neg[1]) : '0;
				oz = (dim == 2'd3) ? to_out(fin.gd[2], !fin.neg[2]) : '0;
			end
			if (!ksel_q && dim != 2'd1 && fin.center)
				ol = {1'b1, LIMP[WORD_BITS-1:0]};
			else
				ol = to_out(fin.l, fin.lneg);
			s = ow[WORD_BITS] | ox[WORD_BITS] | oy[WORD_BITS] | oz[WORD_BITS]
				| ol[WORD_BITS];
			if (fin.ins) begin
				out_data.weight_value    <= ow[WORD_BITS-1:0];
				out_data.grad_x          <= ox[WORD_BITS-1:0];
				out_data.grad_y          <= oy[WORD_BITS-1:0];
				out_data.grad_z          <= oz[WORD_BITS-1:0];
				out_data.laplacian_value <= ol[WORD_BITS-1:0];
				out_data.inside_support  <= 1'b1;
				out_data.saturated       <= s;
			end else begin
				out_data <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/qske_checker.sv =====
// ----------------------------------------------------------------------------
// qske_checker
// Port-level checks for the kernel pipeline.
// ----------------------------------------------------------------------------
module qske_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input qske_pkg::qske_out_t out_data
);
	import qske_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.inside_support |->
		out_data.weight_value == 0 && !out_data.saturated)
		else $error("nonzero result outside support");

	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_data.weight_value[31])
		else $error("negative weight");

endmodule

bind quadratic_sph_kernel_eval qske_checker u_qske_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
